### design/tws_pkg.sv
package tws_pkg;

    // Command kinds
    localparam logic [3:0] KIND_WRITE_BYTE  = 4'd0;
    localparam logic [3:0] KIND_READ_BYTE   = 4'd1;
    localparam logic [3:0] KIND_XFER_BYTE   = 4'd2;
    localparam logic [3:0] KIND_CLK_HIGH    = 4'd3;
    localparam logic [3:0] KIND_CLK_LOW     = 4'd4;
    localparam logic [3:0] KIND_CLK_PULSE   = 4'd5;
    localparam logic [3:0] KIND_SDO_HIGH    = 4'd6;
    localparam logic [3:0] KIND_SDO_LOW     = 4'd7;
    localparam logic [3:0] KIND_CLOCKED_BIT = 4'd8;
    localparam logic [3:0] KIND_RAW_BIT     = 4'd9;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSB_FIRST   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 4'd1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIMER_W    = 16;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] tx_byte;
        logic [7:0] sdi_bits;
    } t_cmd;

    typedef struct packed {
        logic       clk_level;
        logic       sdo_level;
        logic [7:0] rx_data;
        logic       last;
    } t_result;

endpackage

### design/three_wire_serial_master.sv
// Three-wire serial master (clock, data-out, data-in). Each accepted command
// produces one result per clock edge, data-out action or raw bit read, the
// final one marked with last and carrying the received byte or bit. Before
// every clock edge the edge timer runs down from max(half_period_ticks, 1).
// A byte command shifts WORD_BITS bits (clamped to 1..8) with a rising and a
// falling clock edge each; clock-high and clock-low commands make one edge,
// clock pulses and clocked bit reads two, data-out actions and raw bit reads
// none. Commands are handled one at a time; a held result at the output only
// delays the next edge or emitted result, and the next command is taken while
// the previous one's final result still waits. Unknown kinds yield no result.
module three_wire_serial_master #(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tws_pkg::t_cmd                      i_in,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tws_pkg::t_result                   o_out,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tws_pkg::*;

    localparam int unsigned BITS_USED = (WORD_BITS < 1) ? 1 : ((WORD_BITS > 8) ? 8 : WORD_BITS);
    localparam int unsigned CNT_W     = $clog2(BITS_USED + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE_HI,
        S_EDGE_LO,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_BYTE,
        M_PULSE,
        M_HIGH,
        M_LOW
    } t_mode;

    t_state                 r_state;
    t_mode                  r_mode;
    logic                   r_send;
    logic                   r_recv;
    logic                   r_msb_first;
    logic [TIMER_W-1:0]     r_half_period;
    logic [TIMER_W-1:0]     r_timer;
    logic [CNT_W-1:0]       r_cnt;
    logic [BITS_USED-1:0]   r_tx;
    logic [BITS_USED-1:0]   r_rx;
    logic [7:0]             r_sdi;
    logic                   r_clk_line;
    logic                   r_sdo_line;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_xfer;
    logic                   out_free;
    logic                   timer_done;
    logic                   fire;
    logic                   load_out;
    logic [TIMER_W-1:0]     timer_load;
    logic                   tx_bit;
    logic                   sdi_bit;
    logic                   last_bit;
    logic [BITS_USED-1:0]   rx_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign timer_done = (r_timer <= TIMER_W'(1));
    assign fire       = timer_done && out_free;
    assign timer_load = (r_half_period == '0) ? TIMER_W'(1) : r_half_period;
    assign last_bit   = (r_cnt == CNT_W'(BITS_USED - 1));
    assign sdi_bit    = r_sdi[0];
    assign tx_bit     = r_msb_first ? r_tx[BITS_USED-1] : r_tx[0];

    // a new result enters the output register this cycle
    assign load_out = ((r_state == S_EMIT) && out_free)
                   || (((r_state == S_EDGE_HI) || (r_state == S_EDGE_LO)) && fire);

    // shift the sampled bit into the receive word in the configured order
    always_comb begin
        if (r_msb_first) begin
            rx_next = (r_rx << 1) | BITS_USED'(sdi_bit);
        end else begin
            rx_next = (r_rx >> 1) | (BITS_USED'(sdi_bit) << (BITS_USED - 1));
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first   <= 1'b1;
            r_half_period <= TIMER_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MSB_FIRST) begin
                r_msb_first <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data[TIMER_W-1:0];
            end
        end
    end

    // sequencer: decode commands, time edges, shift bits, load results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_BYTE;
            r_send      <= 1'b0;
            r_recv      <= 1'b0;
            r_clk_line  <= 1'b0;
            r_sdo_line  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timer     <= '0;
            r_cnt       <= '0;
        end else begin
            // drop a result once the consumer has taken it and nothing replaces it
            if (r_out_valid && !i_out_stall && !load_out) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_tx   <= i_in.tx_byte[BITS_USED-1:0];
                        r_sdi  <= i_in.sdi_bits;
                        r_cnt  <= '0;
                        r_send <= (i_in.kind == KIND_WRITE_BYTE)
                               || (i_in.kind == KIND_XFER_BYTE);
                        r_recv <= (i_in.kind == KIND_READ_BYTE)
                               || (i_in.kind == KIND_XFER_BYTE)
                               || (i_in.kind == KIND_CLOCKED_BIT)
                               || (i_in.kind == KIND_RAW_BIT);
                        unique case (i_in.kind)
                            KIND_WRITE_BYTE, KIND_READ_BYTE, KIND_XFER_BYTE: begin
                                r_mode  <= M_BYTE;
                                r_rx    <= '0;
                                r_timer <= timer_load;
                                r_state <= S_EDGE_HI;
                            end
                            KIND_CLK_HIGH: begin
                                r_mode  <= M_HIGH;
                                r_timer <= timer_load;
                                r_state <= S_EDGE_HI;
                            end
                            KIND_CLK_LOW: begin
                                r_mode  <= M_LOW;
                                r_timer <= timer_load;
                                r_state <= S_EDGE_LO;
                            end
                            KIND_CLK_PULSE: begin
                                r_mode  <= M_PULSE;
                                r_timer <= timer_load;
                                r_state <= S_EDGE_HI;
                            end
                            KIND_CLOCKED_BIT: begin
                                r_mode  <= M_PULSE;
                                r_rx    <= BITS_USED'(i_in.sdi_bits[0]);
                                r_timer <= timer_load;
                                r_state <= S_EDGE_HI;
                            end
                            KIND_SDO_HIGH, KIND_SDO_LOW: begin
                                r_sdo_line <= (i_in.kind == KIND_SDO_HIGH);
                                r_state    <= S_EMIT;
                            end
                            KIND_RAW_BIT: begin
                                r_rx    <= BITS_USED'(i_in.sdi_bits[0]);
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.clk_level   <= r_clk_line;
                        r_out.sdo_level   <= r_sdo_line;
                        r_out.rx_data     <= r_recv ? 8'(r_rx) : 8'd0;
                        r_out.last        <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end

                S_EDGE_HI: begin
                    if (!timer_done) begin
                        r_timer <= r_timer - TIMER_W'(1);
                    end else if (fire) begin
                        // drive data-out, raise the clock, sample data-in
                        r_clk_line      <= 1'b1;
                        r_out_valid     <= 1'b1;
                        r_out.clk_level <= 1'b1;
                        r_out.rx_data   <= 8'd0;
                        r_out.last      <= (r_mode == M_HIGH);
                        if (r_mode == M_BYTE) begin
                            if (r_send) begin
                                r_sdo_line      <= tx_bit;
                                r_out.sdo_level <= tx_bit;
                            end else begin
                                r_out.sdo_level <= r_sdo_line;
                            end
                            if (r_msb_first) begin
                                r_tx <= r_tx << 1;
                            end else begin
                                r_tx <= r_tx >> 1;
                            end
                            if (r_recv) begin
                                r_rx <= rx_next;
                            end
                            r_sdi <= r_sdi >> 1;
                        end else begin
                            r_out.sdo_level <= r_sdo_line;
                        end
                        if (r_mode == M_HIGH) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_timer <= timer_load;
                            r_state <= S_EDGE_LO;
                        end
                    end
                end

                S_EDGE_LO: begin
                    if (!timer_done) begin
                        r_timer <= r_timer - TIMER_W'(1);
                    end else if (fire) begin
                        // lower the clock; the final edge carries the received value
                        r_clk_line      <= 1'b0;
                        r_out_valid     <= 1'b1;
                        r_out.clk_level <= 1'b0;
                        r_out.sdo_level <= r_sdo_line;
                        if (r_mode == M_BYTE && !last_bit) begin
                            r_out.rx_data <= 8'd0;
                            r_out.last    <= 1'b0;
                            r_cnt         <= r_cnt + CNT_W'(1);
                            r_timer       <= timer_load;
                            r_state       <= S_EDGE_HI;
                        end else begin
                            r_out.rx_data <= r_recv ? 8'(r_rx) : 8'd0;
                            r_out.last    <= 1'b1;
                            r_cnt         <= '0;
                            r_state       <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
